// ===== hdl/timetable_segment_frame_composer_macros.svh =====
// ----------------------------------------------------------------------------
// Timetable segment frame composer - assertion macros
// Shared property wrappers for the RTL assertion blocks.
// ----------------------------------------------------------------------------
`ifndef TIMETABLE_SEGMENT_FRAME_COMPOSER_MACROS_SVH
`define TIMETABLE_SEGMENT_FRAME_COMPOSER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TTSFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define TTSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ttsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttsfc_pkg
// Shared widths, character codes, glyph tables and types of the frame composer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsfc_pkg;

    localparam int REC_LEN = 36;
    localparam int REC_AW  = 6;

    localparam int OP_W         = 1;
    localparam int BYTE_INDEX_W = 6;
    localparam int BYTE_W       = 8;
    localparam int DIGIT_ROW_W  = 4;
    localparam int CHAIN_POS_W  = 2;
    localparam int SEG_W        = 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [7:0] SEG_DASH = 8'h01;
    localparam logic [7:0] SEG_DOT  = 8'h80;
    localparam logic [7:0] SEG_ALL  = 8'hFF;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_Z    = 8'h5A;

    localparam int LET_COUNT = 23;

    localparam logic [7:0] LET_GLYPH [0:LET_COUNT-1] = '{
        8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'hFF, 8'hFF, 8'h37, 8'h30, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'h15, 8'hFF, 8'h67, 8'hFF, 8'h05, 8'h5B, 8'h0F, 8'h1C, 8'hFF, 8'hFF
    };

    localparam logic [7:0] DIG_GLYPH [0:9] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    // Fixed clock legends, one byte per digit position
    localparam logic [7:0] CLK_ERR  [0:3] = '{8'h01, 8'h4F, 8'h05, 8'h05};
    localparam logic [7:0] CLK_INIT [0:3] = '{8'h30, 8'h15, 8'h30, 8'h0F};
    localparam logic [7:0] CLK_PAR  [0:3] = '{8'h01, 8'h67, 8'h77, 8'h05};
    localparam logic [7:0] CLK_TAF  [0:3] = '{8'h01, 8'h0F, 8'h77, 8'hFF};

    // SUPP legend of a cancelled train
    localparam logic [7:0] TT_SUPP  [0:3] = '{8'h5B, 8'h1C, 8'h67, 8'h67};

    localparam logic [8*REC_LEN-1:0] BOOT_TEXT = "L--------002-----005-----002-----000";

    typedef enum logic [1:0] {
        K_TIME  = 2'd0,
        K_CLOCK = 2'd1,
        K_ID    = 2'd2
    } t_kind;

    // Frame-wide context gathered before the words are composed
    typedef struct packed {
        logic [3:0] is_s;
        logic [3:0] is_t;
        logic [3:0] dash1;
        logic [7:0] c0;
        logic       blink;
        logic       stale;
        logic       conn;
    } t_ctx;

    // Which word the shared unit composes
    typedef struct packed {
        t_kind      kind;
        logic [1:0] train;
        logic [1:0] digit;
    } t_req;

    function automatic logic [7:0] glyph_digit(input logic [7:0] c);
        logic [3:0] di;
        di = 4'(c - CH_ZERO);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return DIG_GLYPH[di];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] glyph_letter(input logic [7:0] c);
        logic [4:0] li;
        li = 5'(c - CH_A);
        if (c >= CH_A && c < CH_A + 8'(LET_COUNT)) begin
            return LET_GLYPH[li];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] boot_byte(input logic [REC_AW-1:0] i);
        return BOOT_TEXT[8*(REC_LEN-1-int'(i)) +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ttsfc_in_if.sv =====
// ----------------------------------------------------------------------------
// ttsfc_in_if
// Command channel: load one record byte or render the frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttsfc_in_if
    import ttsfc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]       byte_value;
    logic                    blink_phase;
    logic                    timed_out;
    logic                    show_connections;

    modport source (
        output valid, op, byte_index, byte_value, blink_phase, timed_out, show_connections,
        input  ready
    );

    modport sink (
        input  valid, op, byte_index, byte_value, blink_phase, timed_out, show_connections,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/ttsfc_out_if.sv =====
// ----------------------------------------------------------------------------
// ttsfc_out_if
// Segment word channel towards the chained display drivers.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttsfc_out_if
    import ttsfc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [DIGIT_ROW_W-1:0] digit_row;
    logic [CHAIN_POS_W-1:0] chain_position;
    logic [SEG_W-1:0]       segments;
    logic                   last;

    modport source (
        output valid, digit_row, chain_position, segments, last,
        input  ready
    );

    modport sink (
        input  valid, digit_row, chain_position, segments, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/timetable_segment_frame_composer.sv =====
// ----------------------------------------------------------------------------
// timetable_segment_frame_composer
// Holds the 36-byte timetable record and renders it as 24 segment words.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Word contents
//  --------  ---  -------------  ----------------------------------------------
//  i_cmd     in   valid/ready    op, byte_index, byte_value, blink_phase,
//                                timed_out, show_connections
//  o_word    out  valid/ready    digit_row, chain_position, segments, last
//
//  A load word writes the record RAM at the edge that takes it; ready stays
//  high. A render fetches the context, then takes each segment word through
//  RAM read, glyph compose and hand-over, and holds a word while the output
//  stalls; the single RAM read port and the one glyph unit serve the words
//  in turn. Ready stays low for the whole render.
//  Reset clears the 36 record valid bits, not the record RAM; an unwritten
//  byte reads as the loading-screen text, so no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timetable_segment_frame_composer_macros.svh"

module timetable_segment_frame_composer
    import ttsfc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ttsfc_in_if.sink   i_cmd,
    ttsfc_out_if.source o_word
);

    // Sequencer: fetch context, then read / compose / send each word
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PRE  = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_SEND = 5'b10000
    } t_state;

    localparam logic [3:0] PRE_LAST = 4'd9;

    t_state            r_state, n_state;
    logic [3:0]        r_pcnt,  n_pcnt;
    logic [2:0]        r_row,   n_row;
    logic [1:0]        r_pos,   n_pos;
    logic [REC_LEN-1:0] r_valid;
    logic              r_rd_valid;
    logic [REC_AW-1:0] r_rd_addr;
    t_ctx              r_ctx;
    logic [7:0]        r_seg;

    logic              cmd_take;
    logic              word_take;
    logic              ram_we;
    logic [REC_AW-1:0] raddr;
    logic [REC_AW-1:0] pre_addr;
    logic [REC_AW-1:0] word_addr;
    logic [7:0]        ram_rdata;
    logic [7:0]        rd_byte;
    logic [3:0]        cap_idx;
    logic [1:0]        cap_train;
    logic [1:0]        pre_t_lo;
    logic [1:0]        pre_t_hi;
    logic [1:0]        k;
    logic              word_last;
    t_req              req;
    logic [7:0]        glyph_seg;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_take    = i_cmd.valid && i_cmd.ready;
    assign word_take   = o_word.valid && o_word.ready;

    // Drop loads beyond the record
    assign ram_we = cmd_take && (i_cmd.op == OP_LOAD) &&
                    (i_cmd.byte_index < BYTE_INDEX_W'(REC_LEN));

    // Context fetch: byte 0, the four status bytes, the four first time bytes
    assign pre_t_lo = 2'(r_pcnt - 4'd1);
    assign pre_t_hi = 2'(r_pcnt - 4'd5);

    always_comb begin
        if (r_pcnt == 4'd0) begin
            pre_addr = '0;
        end else if (r_pcnt <= 4'd4) begin
            pre_addr = 6'd9 + {1'b0, pre_t_lo, 3'b000};
        end else if (r_pcnt <= 4'd8) begin
            pre_addr = 6'd5 + {1'b0, pre_t_hi, 3'b000};
        end else begin
            pre_addr = '0;
        end
    end

    // Byte behind the current word
    assign k = r_row[1:0];

    always_comb begin
        word_addr = '0;
        req.kind  = K_TIME;
        req.train = 2'd0;
        req.digit = k;
        case (r_pos)
            2'd0: begin
                word_addr = r_row[2] ? (6'd13 + {4'b0, k}) : (6'd5 + {4'b0, k});
                req.train = r_row[2] ? 2'd1 : 2'd0;
            end
            2'd1: begin
                if (r_row[2]) begin
                    word_addr = 6'd4 + {1'b0, k, 3'b000} + (r_ctx.conn ? 6'd6 : 6'd0);
                    req.kind  = K_ID;
                    req.train = k;
                end else begin
                    word_addr = {4'b0, k};
                    req.kind  = K_CLOCK;
                end
            end
            2'd2: begin
                word_addr = r_row[2] ? (6'd21 + {4'b0, k}) : (6'd29 + {4'b0, k});
                req.train = r_row[2] ? 2'd2 : 2'd3;
            end
            default: begin
                word_addr = '0;
            end
        endcase
    end

    assign raddr = (r_state == S_PRE) ? pre_addr : word_addr;

    ttsfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (REC_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.byte_index),
        .i_wdata (i_cmd.byte_value),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Unwritten entries read as the loading-screen text
    assign rd_byte = r_rd_valid ? ram_rdata : boot_byte(r_rd_addr);

    ttsfc_glyph u_glyph (
        .i_ctx  (r_ctx),
        .i_req  (req),
        .i_char (rd_byte),
        .o_seg  (glyph_seg)
    );

    assign word_last = (r_row == 3'd7) && (r_pos == 2'd2);

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_pcnt  = r_pcnt;
        n_row   = r_row;
        n_pos   = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_take && (i_cmd.op == OP_RENDER)) begin
                    n_state = S_PRE;
                    n_pcnt  = '0;
                    n_row   = '0;
                    n_pos   = '0;
                end
            end
            S_PRE: begin
                n_pcnt = r_pcnt + 4'd1;
                if (r_pcnt == PRE_LAST) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (word_take) begin
                    if (word_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD;
                        if (r_pos == 2'd2) begin
                            n_pos = '0;
                            n_row = r_row + 3'd1;
                        end else begin
                            n_pos = r_pos + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pcnt  <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_pcnt  <= n_pcnt;
            r_row   <= n_row;
            r_pos   <= n_pos;
            if (ram_we) begin
                r_valid[i_cmd.byte_index] <= 1'b1;
            end
        end
    end

    // Capture index trails the fetch address by the RAM read latency
    assign cap_idx   = r_pcnt - 4'd1;
    assign cap_train = (cap_idx <= 4'd4) ? 2'(cap_idx - 4'd1) : 2'(cap_idx - 4'd5);

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[raddr];
        r_rd_addr  <= raddr;
        if (cmd_take) begin
            r_ctx.blink <= i_cmd.blink_phase;
            r_ctx.stale <= i_cmd.timed_out;
            r_ctx.conn  <= i_cmd.show_connections;
        end
        if ((r_state == S_PRE) && (r_pcnt != 4'd0)) begin
            if (cap_idx == 4'd0) begin
                r_ctx.c0 <= rd_byte;
            end else if (cap_idx <= 4'd4) begin
                r_ctx.is_s[cap_train] <= (rd_byte == CH_S);
                r_ctx.is_t[cap_train] <= (rd_byte == CH_T);
            end else begin
                r_ctx.dash1[cap_train] <= (rd_byte == CH_DASH);
            end
        end
        if (r_state == S_CMP) begin
            r_seg <= glyph_seg;
        end
    end

    assign o_word.valid          = (r_state == S_SEND);
    assign o_word.digit_row      = {1'b0, r_row} + 4'd1;
    assign o_word.chain_position = r_pos;
    assign o_word.segments       = r_seg;
    assign o_word.last           = word_last;

    // Assertions
    `TTSFC_ASSERT_NOW(a_last_is_final_slot, i_clk, i_rst_n,
        o_word.valid && o_word.last,
        (o_word.digit_row == 4'd8) && (o_word.chain_position == 2'd2),
        "last flag on a word other than row 8, position 2")
    `TTSFC_ASSERT_NOW(a_no_take_while_sending, i_clk, i_rst_n,
        o_word.valid, !i_cmd.ready,
        "command ready while a segment word is pending")
    `TTSFC_ASSERT_NEXT(a_render_starts_fetch, i_clk, i_rst_n,
        i_cmd.valid && i_cmd.ready && (i_cmd.op == OP_RENDER),
        (r_state == S_PRE) && (r_pcnt == 4'd0),
        "render accepted without starting the context fetch")
    `TTSFC_ASSERT_NEXT(a_next_word_read, i_clk, i_rst_n,
        o_word.valid && o_word.ready && !o_word.last,
        r_state == S_RD,
        "word taken but the next read did not follow")

endmodule

`default_nettype wire

// ===== hdl/ttsfc_ram.sv =====
// ----------------------------------------------------------------------------
// ttsfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/ttsfc_glyph.sv =====
// ----------------------------------------------------------------------------
// ttsfc_glyph
// Shared glyph unit: turns one record character into one segment word.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsfc_glyph
    import ttsfc_pkg::*;
(
    input  wire t_ctx       i_ctx,
    input  wire t_req       i_req,
    input  wire logic [7:0] i_char,
    output logic      [7:0] o_seg
);

    logic [7:0] dot_rt;
    logic [7:0] dot_k1;
    logic [7:0] dot_clk;

    always_comb begin
        dot_rt  = i_ctx.is_t[i_req.train] ? SEG_DOT : 8'h00;
        dot_k1  = (i_req.digit == 2'd1) ? SEG_DOT : 8'h00;
        dot_clk = ((i_req.digit == 2'd1) && ((|i_ctx.is_t) || i_ctx.blink)) ? SEG_DOT : 8'h00;
        o_seg   = 8'h00;
        unique case (i_req.kind)
            K_TIME: begin
                if (i_ctx.is_s[i_req.train] && i_ctx.blink) begin
                    o_seg = TT_SUPP[i_req.digit];
                end else if (i_ctx.dash1[i_req.train] || i_ctx.stale) begin
                    o_seg = SEG_DASH;
                end else begin
                    o_seg = glyph_digit(i_char) | dot_rt | dot_k1;
                end
            end
            K_CLOCK: begin
                if (i_ctx.stale) begin
                    o_seg = CLK_ERR[i_req.digit];
                end else if (i_ctx.c0 == CH_DASH) begin
                    o_seg = SEG_DASH;
                end else if (i_ctx.c0 == CH_L) begin
                    o_seg = CLK_INIT[i_req.digit];
                end else if (i_ctx.c0 == CH_P) begin
                    o_seg = CLK_PAR[i_req.digit];
                end else if (i_ctx.c0 == CH_B) begin
                    o_seg = CLK_TAF[i_req.digit];
                end else begin
                    o_seg = glyph_digit(i_char) | dot_clk;
                end
            end
            K_ID: begin
                if (i_ctx.conn) begin
                    if (i_char == CH_DASH) begin
                        o_seg = SEG_DASH;
                    end else if (i_char == CH_Z) begin
                        o_seg = glyph_letter(CH_T);
                    end else begin
                        o_seg = glyph_digit(i_char);
                    end
                end else begin
                    if (i_char == CH_DASH || i_char == CH_X) begin
                        o_seg = SEG_DASH;
                    end else begin
                        o_seg = glyph_letter(i_char);
                    end
                end
            end
            default: begin
                o_seg = 8'h00;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== verif/tb_timetable_segment_frame_composer.sv =====
// ----------------------------------------------------------------------------
// tb_timetable_segment_frame_composer
// Self-checking bench for the timetable frame composer. A short table of
// directed commands (clock legends, cancelled and real-time trains, ids,
// out-of-table characters, loads past the record) runs first. A longer
// stream of random slot, clock and single-byte loads mixed with renders
// follows. Every segment word is checked against an in-bench model of the
// record and glyph rules, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timetable_segment_frame_composer
    import ttsfc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 235;
    localparam int MAX_IDLE     = 11;
    localparam int DRAIN_CYCLES = 120;   // a full render plus margin

    localparam logic [7:0] CH_U = "U";

    // Loading screen held in the record after reset
    localparam logic [8*REC_LEN-1:0] LOADING_TEXT = "L--------002-----005-----002-----000";

    localparam logic [7:0] LETTER_SEGS [0:22] = '{
        8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'hFF, 8'hFF, 8'h37, 8'h30, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'h15, 8'hFF, 8'h67, 8'hFF, 8'h05, 8'h5B, 8'h0F, 8'h1C, 8'hFF, 8'hFF
    };
    localparam logic [7:0] DIGIT_SEGS [0:9] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    // One command word; legend_known marks a row whose clock legend is typed in
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [BYTE_INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]       val;
        logic                    blink;
        logic                    stale;
        logic                    conn;
        logic                    legend_known;
        logic [31:0]             legend;
    } t_cmd_step;

    typedef struct packed {
        logic [DIGIT_ROW_W-1:0] row;
        logic [CHAIN_POS_W-1:0] pos;
        logic [SEG_W-1:0]       seg;
        logic                   last;
    } t_seg_word;

    // Directed table: walk the clock legends, a real-time and a cancelled
    // train, connection and name glyphs, and loads that must be dropped.
    localparam int DIRECTED_LEN = 25;
    localparam t_cmd_step DIRECTED [0:DIRECTED_LEN-1] = '{
        '{OP_RENDER, 6'd0,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'h3015300F}, // init after reset
        '{OP_RENDER, 6'd63, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'h014F0505}, // stale: err
        '{OP_LOAD,   6'd0,  "P",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'h01677705}, // par
        '{OP_LOAD,   6'd0,  "B",   1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 32'h010F77FF}, // taf
        '{OP_LOAD,   6'd0,  "-",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 32'h01010101}, // dashes
        '{OP_LOAD,   6'd0,  "2",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd1,  "3",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd2,  "5",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd3,  "9",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 32'h6DF95B7B}, // blinking dot
        '{OP_LOAD,   6'd5,  "1",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd9,  "T",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'h6DF95B7B}, // real-time dot
        '{OP_LOAD,   6'd4,  "X",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd10, "Z",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd17, "S",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0},
        '{OP_LOAD,   6'd36, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd63, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd12, "Y",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD,   6'd20, "F",   1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{OP_RENDER, 6'd0,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0}
    };

    logic i_clk;
    logic i_rst_n;

    ttsfc_in_if  cmd_if ();
    ttsfc_out_if word_if ();

    timetable_segment_frame_composer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_word  (word_if)
    );

    logic [7:0] record_copy [0:REC_LEN-1];   // bench copy of the record
    t_seg_word  frame_words_q [$];           // words still owed by the block
    int         fault_count;
    bit         calm_in;                     // no idling on the command side
    bit         calm_out;                    // no stalls on the word side

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Worst case: every item a render, each word held off for the longest
    // stall; the timeout allows many times that.
    initial begin
        #(20_000_000);
        $display("timetable_segment_frame_composer test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Glyph rules
    // ------------------------------------------------------------------------
    function automatic logic [7:0] digit_seg(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return DIGIT_SEGS[4'(c - CH_ZERO)];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] letter_seg(input logic [7:0] c);
        if (c >= CH_A && c <= CH_A + 8'd22) begin
            return LETTER_SEGS[5'(c - CH_A)];
        end
        return 8'h00;
    endfunction

    // Four digit positions of a train time, first digit in the top byte
    function automatic logic [31:0] train_face(input int t, input logic blink,
                                               input logic stale);
        int         base;
        logic [7:0] status;
        logic [7:0] rt_dot;
        logic [31:0] f;
        base   = 4 + 8 * t;
        status = record_copy[REC_AW'(base + 5)];
        if (status == CH_S && blink) begin
            f = {letter_seg(CH_S), letter_seg(CH_U), letter_seg(CH_P), letter_seg(CH_P)};
        end else if (record_copy[REC_AW'(base + 1)] == CH_DASH || stale) begin
            f = {4{SEG_DASH}};
        end else begin
            rt_dot = (status == CH_T) ? SEG_DOT : 8'h00;
            for (int k = 0; k < 4; k++) begin
                f[31 - 8 * k -: 8] = digit_seg(record_copy[REC_AW'(base + 1 + k)]) | rt_dot;
            end
            f[23:16] = f[23:16] | SEG_DOT;
        end
        return f;
    endfunction

    function automatic logic [31:0] clock_face(input logic blink, input logic stale);
        logic [7:0]  c;
        logic        any_rt;
        logic [31:0] f;
        c      = record_copy[0];
        any_rt = 1'b0;
        if (stale) begin
            f = {SEG_DASH, 8'h4F, 8'h05, 8'h05};
        end else if (c == CH_DASH) begin
            f = {4{SEG_DASH}};
        end else if (c == CH_L) begin
            f = {8'h30, 8'h15, 8'h30, 8'h0F};
        end else if (c == CH_P) begin
            f = {SEG_DASH, 8'h67, 8'h77, 8'h05};
        end else if (c == CH_B) begin
            f = {SEG_DASH, 8'h0F, 8'h77, 8'hFF};
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (record_copy[REC_AW'(4 + 8 * k + 5)] == CH_T) any_rt = 1'b1;
                f[31 - 8 * k -: 8] = digit_seg(record_copy[REC_AW'(k)]);
            end
            if (any_rt || blink) f[23:16] = f[23:16] | SEG_DOT;
        end
        return f;
    endfunction

    function automatic logic [7:0] train_badge(input int t, input logic conn);
        int         base;
        logic [7:0] c;
        base = 4 + 8 * t;
        if (conn) begin
            c = record_copy[REC_AW'(base + 6)];
            if (c == CH_DASH) return SEG_DASH;
            if (c == CH_Z) return letter_seg(CH_T);
            return digit_seg(c);
        end
        c = record_copy[REC_AW'(base)];
        if (c == CH_DASH || c == CH_X) return SEG_DASH;
        return letter_seg(c);
    endfunction

    // Queue the 24 words of one render; a typed-in legend overrides the
    // computed clock column
    task automatic queue_frame(input t_cmd_step s);
        logic [31:0] faces [0:3];
        logic [31:0] clk_face;
        logic [7:0]  w [0:2];
        t_seg_word   e;
        int          n;
        for (int t = 0; t < 4; t++) faces[2'(t)] = train_face(t, s.blink, s.stale);
        clk_face = s.legend_known ? s.legend : clock_face(s.blink, s.stale);
        n = 0;
        for (int r = 0; r < 8; r++) begin
            if (r < 4) begin
                w[0] = faces[0][31 - 8 * r -: 8];
                w[1] = clk_face[31 - 8 * r -: 8];
                w[2] = faces[3][31 - 8 * r -: 8];
            end else begin
                w[0] = faces[1][31 - 8 * (r - 4) -: 8];
                w[1] = train_badge(r - 4, s.conn);
                w[2] = faces[2][31 - 8 * (r - 4) -: 8];
            end
            for (int p = 0; p < 3; p++) begin
                e.row  = DIGIT_ROW_W'(r + 1);
                e.pos  = CHAIN_POS_W'(p);
                e.seg  = w[2'(p)];
                e.last = (n == 23);
                frame_words_q.push_back(e);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Idle for a random number of cycles (none in a calm stretch), present
    // the word, hold it until taken, then update the model at that edge.
    // Entered and left at a falling edge.
    task automatic send_cmd(input t_cmd_step s);
        int gap;
        if ($urandom_range(0, 19) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.op               = s.op;
        cmd_if.byte_index       = s.idx;
        cmd_if.byte_value       = s.val;
        cmd_if.blink_phase      = s.blink;
        cmd_if.timed_out        = s.stale;
        cmd_if.show_connections = s.conn;
        cmd_if.valid            = 1'b1;
        do @(posedge i_clk); while (!cmd_if.ready);
        if (s.op == OP_LOAD) begin
            if (s.idx < REC_LEN) record_copy[s.idx] = s.val;
        end else begin
            queue_frame(s);
        end
        @(negedge i_clk);
    endtask

    // Load word with random don't-care fields so their bits toggle too
    function automatic t_cmd_step load_step(input int idx, input logic [7:0] val);
        t_cmd_step s;
        s        = '0;
        s.op     = OP_LOAD;
        s.idx    = BYTE_INDEX_W'(idx);
        s.val    = val;
        s.blink  = 1'($urandom_range(0, 1));
        s.stale  = 1'($urandom_range(0, 1));
        s.conn   = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 5))
            0: return CH_ZERO + 8'($urandom_range(0, 9));
            1: return CH_DASH;
            2: begin
                case ($urandom_range(0, 6))
                    0: return CH_S;
                    1: return CH_T;
                    2: return CH_Z;
                    3: return CH_X;
                    4: return CH_L;
                    5: return CH_P;
                    default: return CH_B;
                endcase
            end
            3: return CH_A + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Fill one train slot with mostly plausible content
    task automatic write_slot(inout int issued);
        int         base;
        logic [7:0] slot [0:7];
        base = 4 + 8 * $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0:       slot[0] = CH_DASH;
            1:       slot[0] = CH_X;
            2:       slot[0] = CH_A + 8'($urandom_range(0, 25));
            default: slot[0] = CH_A + 8'($urandom_range(0, 22));
        endcase
        slot[1] = ($urandom_range(0, 5) == 0) ? CH_DASH : digit_char();
        for (int k = 2; k < 5; k++) begin
            slot[3'(k)] = ($urandom_range(0, 9) == 0) ? any_char() : digit_char();
        end
        case ($urandom_range(0, 3))
            0:       slot[5] = CH_T;
            1:       slot[5] = CH_S;
            2:       slot[5] = CH_DASH;
            default: slot[5] = any_char();
        endcase
        case ($urandom_range(0, 3))
            0:       slot[6] = CH_DASH;
            1:       slot[6] = CH_Z;
            2:       slot[6] = digit_char();
            default: slot[6] = any_char();
        endcase
        slot[7] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 8; k++) begin
            send_cmd(load_step(base + k, slot[3'(k)]));
        end
        issued += 8;
    endtask

    // Either a clock legend in byte 0 or four digits
    task automatic write_clock(inout int issued);
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       send_cmd(load_step(0, CH_L));
                1:       send_cmd(load_step(0, CH_P));
                2:       send_cmd(load_step(0, CH_B));
                default: send_cmd(load_step(0, CH_DASH));
            endcase
            issued += 1;
        end else begin
            for (int k = 0; k < 4; k++) send_cmd(load_step(k, digit_char()));
            issued += 4;
        end
    endtask

    task automatic send_render(inout int issued);
        t_cmd_step s;
        s       = '0;
        s.op    = OP_RENDER;
        s.idx   = BYTE_INDEX_W'($urandom_range(0, 63));
        s.val   = 8'($urandom_range(0, 255));
        s.blink = 1'($urandom_range(0, 1));
        s.stale = ($urandom_range(0, 4) == 0);
        s.conn  = 1'($urandom_range(0, 1));
        send_cmd(s);
        issued += 1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int issued;
        i_rst_n                 = 1'b0;
        cmd_if.valid            = 1'b0;
        cmd_if.op               = OP_LOAD;
        cmd_if.byte_index       = '0;
        cmd_if.byte_value       = '0;
        cmd_if.blink_phase      = 1'b0;
        cmd_if.timed_out        = 1'b0;
        cmd_if.show_connections = 1'b0;
        fault_count             = 0;
        calm_in                 = 1'b0;
        for (int i = 0; i < REC_LEN; i++) begin
            record_copy[REC_AW'(i)] = LOADING_TEXT[8 * (REC_LEN - 1 - i) +: 8];
        end

        // Hold reset, then release it at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i]) send_cmd(DIRECTED[i]);

        // Random part: well-formed slot and clock updates with renders in
        // between, plus stray single-byte loads, some past the record
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: send_render(issued);
                4, 5, 6:    write_slot(issued);
                7:          write_clock(issued);
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_cmd(load_step($urandom_range(0, 63), any_char()));
                    end else begin
                        send_cmd(load_step($urandom_range(0, REC_LEN - 1), any_char()));
                    end
                    issued += 1;
                end
            endcase
        end
        cmd_if.valid = 1'b0;

        // Drain outstanding words, then watch for strays
        while (frame_words_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("timetable_segment_frame_composer test passed");
        end else begin
            $display("timetable_segment_frame_composer test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Word side: random stalls, check every word taken
    // ------------------------------------------------------------------------
    initial begin
        int        stall;
        t_seg_word got;
        t_seg_word want;
        word_if.ready = 1'b0;
        calm_out      = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) calm_out = !calm_out;
            stall = calm_out ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                word_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            word_if.ready = 1'b1;
            do @(posedge i_clk); while (!word_if.valid);
            got = '{word_if.digit_row, word_if.chain_position, word_if.segments,
                    word_if.last};
            if (frame_words_q.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected word row=%0d pos=%0d seg=%02h last=%0b",
                         $time, got.row, got.pos, got.seg, got.last);
            end else begin
                want = frame_words_q.pop_front();
                if (got.row !== want.row) begin
                    fault_count++;
                    $display("%0t: digit_row expected %0d actual %0d",
                             $time, want.row, got.row);
                end
                if (got.pos !== want.pos) begin
                    fault_count++;
                    $display("%0t: chain_position expected %0d actual %0d",
                             $time, want.pos, got.pos);
                end
                if (got.seg !== want.seg) begin
                    fault_count++;
                    $display("%0t: segments (row %0d pos %0d) expected %02h actual %02h",
                             $time, want.row, want.pos, want.seg, got.seg);
                end
                if (got.last !== want.last) begin
                    fault_count++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, got.last);
                end
            end
            @(negedge i_clk);
        end
    end

endmodule

`default_nettype wire
